>>> design/dkx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkx_pkg
// Shared types, codes, key strings and small arithmetic helpers for the
// dual-key XOR stream decryptor.
// ----------------------------------------------------------------------------
package dkx_pkg;

    localparam int KindWidth = 2;
    localparam int IdxAWidth = 5;
    localparam int IdxBWidth = 4;
    localparam int CntWidth  = 7;

    // item kinds
    localparam logic [KindWidth-1:0] KIND_DATA    = 2'd0;
    localparam logic [KindWidth-1:0] KIND_SKIP    = 2'd1;
    localparam logic [KindWidth-1:0] KIND_RESTART = 2'd2;

    // register indexes
    localparam logic REG_ENCRYPTED   = 1'b0;
    localparam logic REG_FILE_LENGTH = 1'b1;

    localparam logic [IdxAWidth-1:0] A_LAST = 5'd19;
    localparam logic [IdxBWidth-1:0] B_LAST = 4'd11;

    // keystream commands
    typedef struct packed {
        logic step;     // advance one keystream step
        logic reseed;   // reload from file length
    } t_ks_ctrl;

    // current key material
    typedef struct packed {
        logic [7:0]          key_a;
        logic [7:0]          key_b;
        logic [CntWidth-1:0] counter;
        logic                swap;
    } t_ks_state;

    // key string A, 20 chars; 0 past the end
    function automatic logic [7:0] key_a_char(input logic [IdxAWidth-1:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:  c = "4";
            5'd1:  c = "R";
            5'd2:  c = "a";
            5'd3:  c = "S";
            5'd4:  c = "9";
            5'd5:  c = "D";
            5'd6:  c = "7";
            5'd7:  c = "K";
            5'd8:  c = "a";
            5'd9:  c = "E";
            5'd10: c = "b";
            5'd11: c = "x";
            5'd12: c = "c";
            5'd13: c = "p";
            5'd14: c = "2";
            5'd15: c = "o";
            5'd16: c = "5";
            5'd17: c = "r";
            5'd18: c = "6";
            5'd19: c = "t";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // key string B, 12 chars; 0 past the end
    function automatic logic [7:0] key_b_char(input logic [IdxBWidth-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = "3";
            4'd1:  c = "t";
            4'd2:  c = "R";
            4'd3:  c = "a";
            4'd4:  c = "U";
            4'd5:  c = "x";
            4'd6:  c = "L";
            4'd7:  c = "m";
            4'd8:  c = "E";
            4'd9:  c = "a";
            4'd10: c = "S";
            4'd11: c = "n";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // remainder of a 7-bit value by a constant 4..15: five compare/subtract steps
    function automatic logic [3:0] mod_small(input logic [CntWidth-1:0] x,
                                             input logic [3:0] m);
        logic [10:0] r;
        r = {4'd0, x};
        for (int k = 4; k >= 0; k--) begin
            if (r >= ({7'd0, m} << k)) begin
                r = r - ({7'd0, m} << k);
            end
        end
        return r[3:0];
    endfunction

    // remainder of a 7-bit value by a small constant 1..9: seven compare/subtract steps
    function automatic logic [3:0] mod_var(input logic [CntWidth-1:0] x,
                                           input logic [3:0] d);
        logic [10:0] r;
        r = {4'd0, x};
        for (int k = 6; k >= 0; k--) begin
            if (r >= ({7'd0, d} << k)) begin
                r = r - ({7'd0, d} << k);
            end
        end
        return r[3:0];
    endfunction

endpackage
`default_nettype wire

>>> design/dkx_keystream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkx_keystream
// Keystream state: key counter, two key indices and the nibble-swap flag,
// with the step and reseed rules.
// ----------------------------------------------------------------------------
module dkx_keystream (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dkx_pkg::t_ks_ctrl  i_ctrl,
    input  wire logic [6:0]         i_seed,
    output dkx_pkg::t_ks_state      o_state
);
    import dkx_pkg::*;

    logic [CntWidth-1:0]  r_counter, n_counter;
    logic [IdxAWidth-1:0] r_idx_a,   n_idx_a;
    logic [IdxBWidth-1:0] r_idx_b,   n_idx_b;
    logic                 r_swap,    n_swap;

    logic [IdxAWidth-1:0] inc_a;
    logic [IdxBWidth-1:0] inc_b;
    logic [CntWidth-1:0]  inc_cnt;
    logic [IdxBWidth-1:0] seed_b;
    logic [3:0]           seed_rem_a;

    assign inc_a   = r_idx_a + 5'd1;
    assign inc_b   = r_idx_b + 4'd1;
    assign inc_cnt = r_counter + 7'd1;
    assign seed_b  = mod_small(i_seed, 4'd9) + 4'd1;

    // seed mod seed_b: remainders by every divisor seed_b can take, in parallel
    always_comb begin
        case (seed_b)
            4'd1:    seed_rem_a = 4'd0;
            4'd2:    seed_rem_a = {3'd0, i_seed[0]};
            4'd3:    seed_rem_a = mod_var(i_seed, 4'd3);
            4'd4:    seed_rem_a = {2'd0, i_seed[1:0]};
            4'd5:    seed_rem_a = mod_small(i_seed, 4'd5);
            4'd6:    seed_rem_a = mod_small(i_seed, 4'd6);
            4'd7:    seed_rem_a = mod_small(i_seed, 4'd7);
            4'd8:    seed_rem_a = {1'b0, i_seed[2:0]};
            4'd9:    seed_rem_a = seed_b - 4'd1;
            default: seed_rem_a = 4'd0;
        endcase
    end

    always_comb begin
        n_counter = r_counter;
        n_idx_a   = r_idx_a;
        n_idx_b   = r_idx_b;
        n_swap    = r_swap;
        if (i_ctrl.reseed) begin
            n_counter = i_seed;
            n_idx_b   = seed_b;
            n_idx_a   = {1'b0, seed_rem_a} + 5'd1;
            n_swap    = 1'b0;
        end else if (i_ctrl.step) begin
            n_idx_a = inc_a;
            n_idx_b = inc_b;
            if (inc_a <= A_LAST || inc_b <= B_LAST) begin
                // at most one index wraps here; each wrap toggles swap
                if (inc_a > A_LAST) begin
                    n_idx_a = 5'd1;
                end
                if (inc_b > B_LAST) begin
                    n_idx_b = 4'd1;
                end
                n_swap = r_swap ^ (inc_a > A_LAST) ^ (inc_b > B_LAST);
            end else begin
                n_counter = inc_cnt;
                n_swap    = ~r_swap;
                if (r_swap) begin
                    n_idx_a = {1'b0, mod_small(inc_cnt, 4'd12)} + 5'd6;
                    n_idx_b = mod_small(inc_cnt, 4'd5) + 4'd4;
                end else begin
                    n_idx_a = {1'b0, mod_small(inc_cnt, 4'd15)} + 5'd3;
                    n_idx_b = mod_small(inc_cnt, 4'd7) + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_idx_a   <= 5'd1;
            r_idx_b   <= 4'd1;
            r_swap    <= 1'b0;
        end else begin
            r_counter <= n_counter;
            r_idx_a   <= n_idx_a;
            r_idx_b   <= n_idx_b;
            r_swap    <= n_swap;
        end
    end

    assign o_state.key_a   = key_a_char(r_idx_a);
    assign o_state.key_b   = key_b_char(r_idx_b);
    assign o_state.counter = r_counter;
    assign o_state.swap    = r_swap;

endmodule
`default_nettype wire

>>> design/dual_key_xor_stream_decrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_key_xor_stream_decrypt
// Byte-at-a-time archive stream decryptor with a two-key XOR keystream.
// ----------------------------------------------------------------------------
// One word in, at most one word out, one word per clock sustained while
// i_ready stays high. A data word (kind DATA) gives one output byte; SKIP
// advances the keystream, and RESTART reseeds it from bits 8:2 of file_length;
// neither gives output, nor does the unused kind code. When encryption is off,
// data words pass through unchanged and SKIP/RESTART leave the keystream
// alone. The byte is decrypted with the current keystream state while the
// state steps, both on the accepting edge, and the result sits in the output
// register. That register is the only stage, so o_ready stays high unless a
// result is held back by i_ready. Configuration (register 0 encrypted,
// register 1 file_length) is always accepted and should be written only when
// the stream is idle; writing file_length does not reseed until a RESTART.
// ----------------------------------------------------------------------------
module dual_key_xor_stream_decrypt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_in,
    // output words
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_data_out,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import dkx_pkg::*;

    logic        r_encrypted;
    logic [31:0] r_file_length;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_data_out,  n_data_out;

    logic        in_fire;
    logic        is_data;
    t_ks_ctrl    ks_ctrl;
    t_ks_state   ks_state;
    logic [7:0]  mix_b;
    logic [7:0]  mix_swap;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encrypted   <= 1'b0;
            r_file_length <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENCRYPTED:   r_encrypted   <= i_cfg_data[0];
                REG_FILE_LENGTH: r_file_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept whenever the output slot is empty or drains this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;
    assign is_data = (i_kind == KIND_DATA);

    // keystream moves only with encryption on
    assign ks_ctrl.step   = in_fire && r_encrypted &&
                            (i_kind == KIND_DATA || i_kind == KIND_SKIP);
    assign ks_ctrl.reseed = in_fire && r_encrypted && (i_kind == KIND_RESTART);

    dkx_keystream u_keystream (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ks_ctrl),
        .i_seed  (r_file_length[8:2]),
        .o_state (ks_state)
    );

    // XOR with key B and counter, optional nibble swap, then XOR with key A
    assign mix_b    = i_data_in ^ ks_state.key_b ^ {1'b0, ks_state.counter};
    assign mix_swap = ks_state.swap ? {mix_b[3:0], mix_b[7:4]} : mix_b;

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_data_out  = r_data_out;
        if (in_fire && is_data) begin
            n_out_valid = 1'b1;
            n_data_out  = r_encrypted ? (mix_swap ^ ks_state.key_a) : i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_out <= n_data_out;
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_data_out;

endmodule
`default_nettype wire

>>> design/dkx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkx_checker
// Port-level checks for the stream decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module dkx_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [1:0] i_kind,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_data_out
);
    import dkx_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_out))
        else $error("output word changed while stalled");

    // every accepted data word shows up next cycle
    a_data_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == KIND_DATA |=> o_valid)
        else $error("data word produced no result");

    // non-data words never create a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) && !(i_valid && o_ready && i_kind == KIND_DATA)
        |=> !o_valid)
        else $error("result without a data word");

    // empty output slot means input is open
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind dual_key_xor_stream_decrypt dkx_checker u_dkx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_kind     (i_kind),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_data_out (o_data_out)
);
`default_nettype wire

>>> test/dkx_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkx_stream_checker
// Watches the word and configuration channels of the stream decryptor, runs
// its own copy of the two-key keystream and checks every output byte in order.
// ----------------------------------------------------------------------------
module dkx_stream_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [dkx_pkg::KindWidth-1:0] i_kind,
    input  logic [7:0]                   i_data_in,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [7:0]                   i_data_out,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_end_of_test,
    output int                           o_pending,
    output int                           o_fail_count
);
    import dkx_pkg::*;

    localparam logic [8*20-1:0] KEY_A_STR = "4RaS9D7KaEbxcp2o5r6t";
    localparam logic [8*12-1:0] KEY_B_STR = "3tRaUxLmEaSn";
    localparam int MAX_PRINTED = 100;

    // keystream and register copy
    logic        enc_on;
    logic [31:0] file_len;
    logic [6:0]  ks_count;
    logic [4:0]  ks_idx_a;
    logic [3:0]  ks_idx_b;
    logic        ks_swap;
    logic        end_checked;

    logic [7:0]  plain_q[$];    // decrypted bytes still owed by the block

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        end_checked  = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    // key characters; zero past the end of either string
    function automatic logic [7:0] key_a_at(input logic [4:0] idx);
        int sh;
        sh = 8 * (19 - int'(idx));
        return (idx < 5'd20) ? KEY_A_STR[sh +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] key_b_at(input logic [3:0] idx);
        int sh;
        sh = 8 * (11 - int'(idx));
        return (idx < 4'd12) ? KEY_B_STR[sh +: 8] : 8'h00;
    endfunction

    task automatic ks_advance();
        int a;
        int b;
        int c;
        a = (int'(ks_idx_a) + 1) % 32;
        b = (int'(ks_idx_b) + 1) % 16;
        if (a <= 19 || b <= 11) begin
            // at most one index wraps: back to 1, swap toggles per wrap
            if (a > 19) begin
                a = 1;
                ks_swap = ~ks_swap;
            end
            if (b > 11) begin
                b = 1;
                ks_swap = ~ks_swap;
            end
        end else begin
            ks_count = ks_count + 7'd1;
            c = int'(ks_count);
            if (ks_swap) begin
                ks_swap = 1'b0;
                a = c % 12 + 6;
                b = c % 5 + 4;
            end else begin
                ks_swap = 1'b1;
                a = c % 15 + 3;
                b = c % 7 + 1;
            end
        end
        ks_idx_a = a[4:0];
        ks_idx_b = b[3:0];
    endtask

    task automatic ks_reseed();
        int a;
        int b;
        ks_count = file_len[8:2];
        b = int'(ks_count) % 9 + 1;
        a = int'(ks_count) % b + 1;
        ks_idx_a = a[4:0];
        ks_idx_b = b[3:0];
        ks_swap  = 1'b0;
    endtask

    task automatic decrypt_byte(input logic [7:0] cipher, output logic [7:0] plain);
        logic [7:0] d;
        d = cipher ^ key_b_at(ks_idx_b) ^ {1'b0, ks_count};
        if (ks_swap) begin
            d = {d[3:0], d[7:4]};
        end
        plain = d ^ key_a_at(ks_idx_a);
        ks_advance();
    endtask

    always @(posedge i_clk) begin : watch
        logic [7:0] want;
        if (!i_rst_n) begin
            enc_on   = 1'b0;
            file_len = 32'd0;
            ks_count = 7'd0;
            ks_idx_a = 5'd1;
            ks_idx_b = 4'd1;
            ks_swap  = 1'b0;
            plain_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ENCRYPTED:   enc_on = i_cfg_data[0];
                    REG_FILE_LENGTH: file_len = i_cfg_data;
                    default: ;
                endcase
            end
            // output first: a word leaving now was predicted on an earlier edge
            if (i_out_valid && i_out_ready) begin
                if (plain_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %02h", i_data_out));
                end else begin
                    want = plain_q.pop_front();
                    if (i_data_out !== want) begin
                        report_mismatch($sformatf("data_out %02h, want %02h",
                                                  i_data_out, want));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_DATA: begin
                        if (enc_on) begin
                            decrypt_byte(i_data_in, want);
                        end else begin
                            want = i_data_in;
                        end
                        plain_q.push_back(want);
                    end
                    KIND_SKIP: begin
                        if (enc_on) ks_advance();
                    end
                    KIND_RESTART: begin
                        if (enc_on) ks_reseed();
                    end
                    default: ;
                endcase
            end
            if (i_end_of_test && !end_checked) begin
                end_checked = 1'b1;
                if (plain_q.size() != 0) begin
                    report_mismatch($sformatf("%0d words never arrived", plain_q.size()));
                end
            end
        end
        o_pending <= plain_q.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the dual-key XOR stream decryptor; a checker
// beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
    import dkx_pkg::*;

    // the kind code the block must ignore
    localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;
    localparam int RUN_ITEMS = 950;
    localparam int LIMIT_NS  = 4_000_000;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  in_kind     = KIND_DATA;
    logic [7:0]  in_data     = 8'h00;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [7:0]  out_data;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic        cfg_index   = REG_ENCRYPTED;
    logic [31:0] cfg_data    = 32'd0;
    logic        end_of_test = 1'b0;

    int pending;
    int fail_count;
    int send_idle_pct  = 0;     // chance per cycle that the sender holds off
    int recv_stall_pct = 0;     // chance per cycle that the receiver stalls

    dual_key_xor_stream_decrypt uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_kind      (in_kind),
        .i_data_in   (in_data),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_data_out  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dkx_stream_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (in_kind),
        .i_data_in     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_data_out    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_end_of_test (end_of_test),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case a handshake hangs
    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // Receiver: ready is redrawn every cycle, so stalls land on any phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one word and hold it until accepted. Valid only drops when a gap
    // is drawn, so back-to-back words keep it high without a glitch.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_data  <= data;
        do @(posedge clk); while (!in_ready);
    endtask

    // Register write; caller drops cfg_valid after the last one of a group.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Drain: wait for every owed word, then a few cycles more since skip and
    // restart words give no output but may still be in flight.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial begin : stimulus
        int          done_items;
        int          seg_len;
        int          pick;
        logic        enc;
        logic [1:0]  kind;
        logic [31:0] value;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // encryption off after reset: bytes pass, skip/restart/unused do nothing
        send_word(KIND_DATA, 8'h00);
        send_word(KIND_DATA, 8'hFF);
        send_word(KIND_SKIP, 8'h55);
        send_word(KIND_RESTART, 8'hAA);
        send_word(KIND_UNUSED, 8'hC3);
        send_word(KIND_DATA, 8'h5A);
        settle();

        // encryption on, keystream still at its reset state
        write_reg(REG_ENCRYPTED, 32'd1);
        cfg_valid <= 1'b0;
        send_word(KIND_DATA, 8'h00);
        send_word(KIND_DATA, 8'hFF);
        send_word(KIND_UNUSED, 8'h81);
        send_word(KIND_SKIP, 8'h00);
        send_word(KIND_DATA, 8'h0F);
        send_word(KIND_DATA, 8'hF0);
        settle();

        // a length write alone must not reseed; the restart does
        write_reg(REG_FILE_LENGTH, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_word(KIND_DATA, 8'h33);
        send_word(KIND_RESTART, 8'h00);
        send_word(KIND_DATA, 8'hA5);
        send_word(KIND_DATA, 8'h3C);
        send_word(KIND_SKIP, 8'hFF);
        send_word(KIND_DATA, 8'h96);
        settle();

        // back off with a restart that must be ignored
        write_reg(REG_FILE_LENGTH, 32'd0);
        write_reg(REG_ENCRYPTED, 32'd0);
        cfg_valid <= 1'b0;
        send_word(KIND_RESTART, 8'h00);
        send_word(KIND_DATA, 8'h7E);

        // --- random segments, each under a fresh register setting ---
        done_items = 0;
        while (done_items < RUN_ITEMS) begin
            settle();
            // idle phases follow progress through the run
            case (done_items * 4 / RUN_ITEMS)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 64;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct <= 33;
                end
            endcase

            // mostly encrypted; upper data bits of the flag write are noise
            enc      = ($urandom_range(9) != 0);
            value    = $urandom;
            value[0] = enc;
            write_reg(REG_ENCRYPTED, value);
            case ($urandom_range(5))
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'h0000_01FC;
                default: value = $urandom;
            endcase
            write_reg(REG_FILE_LENGTH, value);
            cfg_valid <= 1'b0;

            // usually start from the file head; otherwise the keystream runs on
            if ($urandom_range(3) != 0) begin
                send_word(KIND_RESTART, 8'($urandom));
                done_items++;
            end
            seg_len = $urandom_range(20, 120);
            repeat (seg_len) begin
                pick = $urandom_range(99);
                if (pick < 78) begin
                    kind = KIND_DATA;
                end else if (pick < 90) begin
                    kind = KIND_SKIP;
                end else if (pick < 93) begin
                    kind = KIND_RESTART;
                end else begin
                    kind = KIND_UNUSED;
                end
                send_word(kind, 8'($urandom));
                done_items++;
            end
        end

        settle();
        end_of_test <= 1'b1;
        repeat (3) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> dual_key_xor_stream_decrypt.f
design/dkx_pkg.sv
design/dkx_keystream.sv
design/dual_key_xor_stream_decrypt.sv
design/dkx_checker.sv
test/dkx_stream_checker.sv
test/testbench.sv
